[design/nwsp_pkg.sv]
// Shared types and constants for the wind sentence parser.
package nwsp_pkg;

    // Input channel kinds (carried on s_tuser)
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result kinds (carried on m_tuser)
    localparam logic STATUS_COMMIT  = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    // Characters the parser reacts to
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_I = 8'h49;

    // Sentence layout and limits
    localparam int           MAX_LINE_DEFAULT = 50;
    localparam logic [15:0]  TIMEOUT_RESET    = 16'd5000;
    localparam logic [14:0]  NUM_MAX          = 15'd32767;
    localparam logic [2:0]   FIELD_DIR        = 3'd1;
    localparam logic [2:0]   FIELD_SPEED      = 3'd3;
    localparam logic [2:0]   FIELD_LAST       = 3'd7;

    // Classified-item queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One classified input beat
    typedef struct packed {
        logic       is_tick;
        logic       is_dollar;
        logic       is_newline;
        logic       is_comma;
        logic       is_plus;
        logic       is_minus;
        logic       is_digit;
        logic       is_i;
        logic [3:0] digit;
    } nwsp_item_t;

    // Number parse progress within a field
    typedef enum logic [2:0] {
        NUM_SIGN   = 3'b001,
        NUM_DIGITS = 3'b010,
        NUM_DONE   = 3'b100
    } num_stage_t;

endpackage

[design/nwsp_front.sv]
// Front end: accepts input beats and classifies them for the back end.
module nwsp_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic                 s_tuser,   // [0] command
    input  logic                 q_full,
    output logic                 q_push,
    output nwsp_pkg::nwsp_item_t q_item
);
    import nwsp_pkg::*;

    logic is_byte;

    // Accept whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign is_byte  = (s_tuser == CMD_BYTE);

    // Decode the character class once, here
    always_comb begin
        q_item.is_tick    = (s_tuser == CMD_TICK);
        q_item.is_dollar  = is_byte && (s_tdata == CH_DOLLAR);
        q_item.is_newline = is_byte && (s_tdata == CH_NEWLINE);
        q_item.is_comma   = is_byte && (s_tdata == CH_COMMA);
        q_item.is_plus    = is_byte && (s_tdata == CH_PLUS);
        q_item.is_minus   = is_byte && (s_tdata == CH_MINUS);
        q_item.is_digit   = is_byte && (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
        q_item.is_i       = is_byte && (s_tdata == CH_UPPER_I);
        q_item.digit      = s_tdata[3:0];
    end

endmodule

[design/nwsp_queue.sv]
// Short FIFO of classified beats between front and back end.
module nwsp_queue #(
    parameter int DEPTH = nwsp_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  nwsp_pkg::nwsp_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output nwsp_pkg::nwsp_item_t pop_item
);
    import nwsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nwsp_item_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entry payload
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop)
        else $error("queue pushed while full");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

[design/nwsp_back.sv]
// Back end: sentence capture, field split, number parse, commit and timeout.
module nwsp_back #(
    parameter int MAX_LINE = nwsp_pkg::MAX_LINE_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 q_not_empty,
    input  nwsp_pkg::nwsp_item_t q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tuser
);
    import nwsp_pkg::*;

    localparam int POS_W = $clog2(MAX_LINE + 1);

    logic               capturing_reg, capturing_next;
    logic               drop_next_reg, drop_next_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               second_i_reg, second_i_next;
    logic [2:0]         field_reg, field_next;
    logic               in_field_reg, in_field_next;
    num_stage_t         stage_reg, stage_next;
    logic               neg_reg, neg_next;
    logic [14:0]        acc_reg, acc_next;
    logic signed [15:0] pdir_reg, pdir_next;
    logic signed [15:0] pspd_reg, pspd_next;
    logic signed [15:0] dir_reg, dir_next;
    logic signed [15:0] spd_reg, spd_next;
    logic [15:0]        tick_reg, tick_next;
    logic [15:0]        timeout_reg;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [31:0]        m_tdata_reg;
    logic               m_tuser_reg;

    logic               res_valid;
    logic               res_status;

    assign q_pop    = q_not_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Execute one classified beat
    always_comb begin
        logic               do_store;
        logic               do_end;
        logic               feed_done;
        logic signed [15:0] close_val;
        logic [18:0]        acc_wide;

        do_store       = 1'b0;
        do_end         = 1'b0;
        feed_done      = 1'b0;
        close_val      = '0;
        acc_wide       = '0;
        capturing_next = capturing_reg;
        drop_next_next = drop_next_reg;
        pos_next       = pos_reg;
        second_i_next  = second_i_reg;
        field_next     = field_reg;
        in_field_next  = in_field_reg;
        stage_next     = stage_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        pdir_next      = pdir_reg;
        pspd_next      = pspd_reg;
        dir_next       = dir_reg;
        spd_next       = spd_reg;
        tick_next      = tick_reg;
        res_valid      = 1'b0;
        res_status     = STATUS_COMMIT;

        if (q_pop) begin
            if (q_item.is_tick) begin
                // Timeout only while hunting; otherwise count up, saturating
                if (!capturing_reg && (tick_reg >= timeout_reg)) begin
                    tick_next  = '0;
                    res_valid  = 1'b1;
                    res_status = STATUS_TIMEOUT;
                end else if (tick_reg != '1) begin
                    tick_next = tick_reg + 1'b1;
                end
            end else if (!capturing_reg) begin
                // Hunting: drop the byte after an overlong line, start on dollar
                if (drop_next_reg) begin
                    drop_next_next = 1'b0;
                end else if (q_item.is_dollar) begin
                    capturing_next = 1'b1;
                    pos_next       = '0;
                    second_i_next  = 1'b0;
                    field_next     = '0;
                    in_field_next  = 1'b0;
                    stage_next     = NUM_SIGN;
                    neg_next       = 1'b0;
                    acc_next       = '0;
                    pdir_next      = dir_reg;
                    pspd_next      = spd_reg;
                    do_store       = 1'b1;
                end
            end else if (q_item.is_newline) begin
                do_end = 1'b1;
            end else begin
                do_store = 1'b1;
            end

            if (do_store) begin
                if (pos_next == POS_W'(1)) begin
                    second_i_next = q_item.is_i;
                end
                if (q_item.is_comma) begin
                    // Close a non-empty field; empty fields are skipped
                    if (in_field_next) begin
                        close_val = neg_next ? -$signed({1'b0, acc_next})
                                             : $signed({1'b0, acc_next});
                        if (field_next == FIELD_DIR) begin
                            pdir_next = close_val;
                        end else if (field_next == FIELD_SPEED) begin
                            pspd_next = close_val;
                        end
                        if (field_next != FIELD_LAST) begin
                            field_next = field_next + 1'b1;
                        end
                        in_field_next = 1'b0;
                    end
                end else begin
                    if (!in_field_next) begin
                        in_field_next = 1'b1;
                        stage_next    = NUM_SIGN;
                        neg_next      = 1'b0;
                        acc_next      = '0;
                    end
                    // Optional sign, then digits until the first other character
                    if (stage_next == NUM_SIGN) begin
                        if (q_item.is_plus || q_item.is_minus) begin
                            neg_next   = q_item.is_minus;
                            stage_next = NUM_DIGITS;
                            feed_done  = 1'b1;
                        end else begin
                            stage_next = q_item.is_digit ? NUM_DIGITS : NUM_DONE;
                        end
                    end
                    if (!feed_done && (stage_next == NUM_DIGITS)) begin
                        if (q_item.is_digit) begin
                            acc_wide = ({4'b0, acc_next} << 3) + ({4'b0, acc_next} << 1)
                                     + 19'(q_item.digit);
                            acc_next = (acc_wide > 19'(NUM_MAX)) ? NUM_MAX : acc_wide[14:0];
                        end else begin
                            stage_next = NUM_DONE;
                        end
                    end
                end
                pos_next = pos_next + 1'b1;
                if (pos_next >= POS_W'(MAX_LINE)) begin
                    drop_next_next = 1'b1;
                    do_end         = 1'b1;
                end
            end

            if (do_end) begin
                // Close the open field, then commit only an 'I' sentence
                if (in_field_next) begin
                    close_val = neg_next ? -$signed({1'b0, acc_next})
                                         : $signed({1'b0, acc_next});
                    if (field_next == FIELD_DIR) begin
                        pdir_next = close_val;
                    end else if (field_next == FIELD_SPEED) begin
                        pspd_next = close_val;
                    end
                    if (field_next != FIELD_LAST) begin
                        field_next = field_next + 1'b1;
                    end
                    in_field_next = 1'b0;
                end
                capturing_next = 1'b0;
                if (second_i_next) begin
                    dir_next   = pdir_next;
                    spd_next   = pspd_next;
                    tick_next  = '0;
                    res_valid  = 1'b1;
                    res_status = STATUS_COMMIT;
                end
            end
        end
    end

    // Output register: load a new result, clear once taken
    always_comb begin
        if (res_valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capturing_reg <= 1'b0;
            drop_next_reg <= 1'b0;
            pos_reg       <= '0;
            second_i_reg  <= 1'b0;
            field_reg     <= '0;
            in_field_reg  <= 1'b0;
            stage_reg     <= NUM_SIGN;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            pdir_reg      <= '0;
            pspd_reg      <= '0;
            dir_reg       <= '0;
            spd_reg       <= '0;
            tick_reg      <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            capturing_reg <= capturing_next;
            drop_next_reg <= drop_next_next;
            pos_reg       <= pos_next;
            second_i_reg  <= second_i_next;
            field_reg     <= field_next;
            in_field_reg  <= in_field_next;
            stage_reg     <= stage_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            pdir_reg      <= pdir_next;
            pspd_reg      <= pspd_next;
            dir_reg       <= dir_next;
            spd_reg       <= spd_next;
            tick_reg      <= tick_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // Hold result payload
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= {spd_next, dir_next};
            m_tuser_reg <= res_status;
        end
    end

`ifndef SYNTHESIS
    a_commit_clears_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res_status == STATUS_COMMIT) |=> tick_reg == '0)
        else $error("commit did not clear the tick count");

    a_timeout_hunting: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res_status == STATUS_TIMEOUT) |-> !capturing_reg)
        else $error("timeout reported during capture");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        capturing_reg |-> pos_reg < POS_W'(MAX_LINE))
        else $error("capture ran past the line limit");

    a_drop_hunting: assert property (@(posedge aclk) disable iff (!aresetn)
        !(drop_next_reg && capturing_reg))
        else $error("drop pending while capturing");
`endif

endmodule

[design/nmea_wind_sentence_parser.sv]
// Top level of the wind sentence parser: front end, queue and back end.
//
// Takes one beat per cycle while the queue has room, either a received character
// or a millisecond tick, and returns a result when an 'I' sentence commits its
// direction and speed or when a tick finds no valid sentence for timeout_ticks ticks.
// Every beat is classified by the front end, held in the queue and executed by the
// back end, so the block sustains one beat per clock while m_tready keeps the output
// free; a result is registered in the output register after its beat leaves the queue.
// A four-entry queue between the two ends and the result register let input keep
// flowing while m_tready is low, until the queue fills.
// The timeout register resets to 5000 and is written through cfg_wr_en.
module nmea_wind_sentence_parser #(
    parameter int MAX_LINE    = nwsp_pkg::MAX_LINE_DEFAULT,
    parameter int QUEUE_DEPTH = nwsp_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // [15:0] timeout_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] rx_byte
    input  logic        s_tuser,      // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // [15:0] direction, [31:16] speed
    output logic        m_tuser       // [0] status
);
    import nwsp_pkg::*;

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    nwsp_item_t push_item;
    nwsp_item_t pop_item;

    // Classify incoming beats
    nwsp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // Decouple the two ends
    nwsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    // Parse, commit and time out
    nwsp_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_not_empty (q_not_empty),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
